// ----- hw/rtl/bfod_pkg.sv -----
// Shared types, constants and register indexes of the band feature object detector.
`timescale 1ns / 1ps
`default_nettype none

package bfod_pkg;

   localparam int CHANNELS_DEFAULT  = 8;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int CHANNEL_W = 3;
   localparam int SAMPLE_W  = 12;
   localparam int FEATURE_W = 28;
   localparam int COEFF_W   = 17;
   localparam int TICKS_W   = 16;
   localparam int CONTROL_W = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 28;
   localparam int TIMER_W   = TICKS_W + 1;
   localparam int ENABLE_W  = 8;
   localparam int SKIP_BIT  = 8;

   localparam logic [COEFF_W-1:0]   LOWPASS_COEFF_RESET    = 17'd655;
   localparam logic [COEFF_W-1:0]   HIGHPASS_COEFF_RESET   = 17'd1966;
   localparam logic [COEFF_W-1:0]   FEATURE_COEFF_RESET    = 17'd1966;
   localparam logic [FEATURE_W-1:0] DETECT_THRESHOLD_RESET = 28'd458752;
   localparam logic [TICKS_W-1:0]   DELAY_TICKS_RESET      = 16'd0;
   localparam logic [TICKS_W-1:0]   DURATION_TICKS_RESET   = 16'd100;
   localparam logic [TICKS_W-1:0]   BLIND_TICKS_RESET      = 16'd1000;
   localparam logic [CONTROL_W-1:0] OUTPUT_CONTROL_RESET   = 9'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LOWPASS_COEFF    = 3'd0,
      REG_HIGHPASS_COEFF   = 3'd1,
      REG_FEATURE_COEFF    = 3'd2,
      REG_DETECT_THRESHOLD = 3'd3,
      REG_DELAY_TICKS      = 3'd4,
      REG_DURATION_TICKS   = 3'd5,
      REG_BLIND_TICKS      = 3'd6,
      REG_OUTPUT_CONTROL   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
   } req_payload_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] out_channel;
      logic [FEATURE_W-1:0] feature;
      logic                 detected;
      logic                 pin_level;
   } rsp_payload_type;

   typedef struct packed {
      logic [COEFF_W-1:0]   lowpass_coeff;
      logic [COEFF_W-1:0]   highpass_coeff;
      logic [COEFF_W-1:0]   feature_coeff;
      logic [FEATURE_W-1:0] detect_threshold;
      logic [TICKS_W-1:0]   delay_ticks;
      logic [TICKS_W-1:0]   duration_ticks;
      logic [TICKS_W-1:0]   blind_ticks;
      logic [CONTROL_W-1:0] output_control;
      logic                 skip_clear;
   } cfg_type;

endpackage

`default_nettype wire

// ----- hw/rtl/band_feature_object_detector_core.sv -----
// Top level of the band feature object detector: sequencer, channel state and timers.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  channel, sample
// rsp_      out        rsp_valid / rsp_stall  out_channel, feature, detected, pin_level
// csr_      in         csr_write_enable       csr_index, csr_write_data
//
// A request is taken only while the sequencer is idle; req_stall is high otherwise.
// Each request makes three filter passes through the single shared multiply-add
// smoother (none for a channel at or above CHANNELS), then a done step for detection
// and timers that waits while the response register stays full; only then does the
// sequencer return to idle. A new request may be accepted while the previous response
// still waits on rsp_stall. Synchronous reset clears every filter, blind counter, parity,
// pin and the response valid flag, and marks the delay and duration timers idle.

module band_feature_object_detector_core
   import bfod_pkg::*;
#(
   parameter int CHANNELS  = CHANNELS_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int VAL_W = SAMPLE_W + FRAC_BITS;
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W = (VAL_W > FEATURE_W) ? VAL_W : FEATURE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOWPASS,
      S_BASELINE,
      S_FEATURE,
      S_DONE
   } state_type;

   cfg_type cfg;

   bfod_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   state_type             state_ff;
   logic [CHANNEL_W-1:0]  channel_ff;
   logic [SAMPLE_W-1:0]   sample_ff;
   logic                  present_ff;
   logic [VAL_W-1:0]      lowpass_new_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_payload_ff;

   // Per-channel state, each entry read at the current channel only.
   logic [VAL_W-1:0]      lowpass_ff  [CHANNELS];
   logic [VAL_W-1:0]      baseline_ff [CHANNELS];
   logic [VAL_W-1:0]      feature_ff  [CHANNELS];
   logic [TICKS_W-1:0]    blind_ff    [CHANNELS];
   logic [TIMER_W-1:0]    delay_ff    [CHANNELS];
   logic [TIMER_W-1:0]    duration_ff [CHANNELS];
   logic                  parity_ff   [CHANNELS];
   logic                  pin_ff      [CHANNELS];

   logic [CH_W-1:0]       ch_idx;
   logic                  req_present;
   logic                  accept;
   logic                  out_free;
   logic                  rsp_load;

   logic                  filt_enable;
   logic [COEFF_W-1:0]    filt_coeff;
   logic [VAL_W-1:0]      filt_x;
   logic [VAL_W-1:0]      filt_y;
   logic [VAL_W-1:0]      filt_result;
   logic [VAL_W-1:0]      band;

   logic [TICKS_W-1:0]    blind_dec;
   logic                  detect;
   logic                  arm;
   logic [TICKS_W-1:0]    blind_in;
   logic                  parity_in;
   logic [TIMER_W-1:0]    delay_armed;
   logic [TIMER_W-1:0]    delay_in;
   logic [TIMER_W-1:0]    duration_loaded;
   logic [TIMER_W-1:0]    duration_in;
   logic                  pin_raised;
   logic                  pin_in;
   logic [ENABLE_W-1:0]   trigger_enable;

   assign ch_idx      = CH_W'(channel_ff);
   assign req_present = ({{(32 - CHANNEL_W){1'b0}}, req_payload.channel} < 32'(CHANNELS));
   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_load    = (state_ff == S_DONE) && out_free;

   // Operand selection for the shared smoother.
   always_comb begin
      band = (lowpass_new_ff >= filt_result) ? (lowpass_new_ff - filt_result)
                                             : (filt_result - lowpass_new_ff);
      filt_enable = 1'b0;
      filt_coeff  = cfg.lowpass_coeff;
      filt_x      = {sample_ff, {FRAC_BITS{1'b0}}};
      filt_y      = lowpass_ff[ch_idx];
      case (state_ff)
         S_LOWPASS: begin
            filt_enable = 1'b1;
         end
         S_BASELINE: begin
            filt_enable = 1'b1;
            filt_coeff  = cfg.highpass_coeff;
            filt_x      = filt_result;
            filt_y      = baseline_ff[ch_idx];
         end
         S_FEATURE: begin
            filt_enable = 1'b1;
            filt_coeff  = cfg.feature_coeff;
            filt_x      = band;
            filt_y      = feature_ff[ch_idx];
         end
         default: begin
         end
      endcase
   end

   bfod_smoother #(
      .FRAC_BITS (FRAC_BITS)
   ) u_smoother (
      .clock    (clock),
      .enable   (filt_enable),
      .coeff    (filt_coeff),
      .x_value  (filt_x),
      .y_value  (filt_y),
      .result   (filt_result)
   );

   // Detection and timers, evaluated in the final state when the new feature is in
   // the smoother's result register. A detection re-arms the delay first, then the
   // delay timer is served, then the duration timer, all on the same sample.
   always_comb begin
      trigger_enable = cfg.output_control[ENABLE_W-1:0];
      blind_dec = (blind_ff[ch_idx] != '0) ? (blind_ff[ch_idx] - TICKS_W'(1))
                                           : blind_ff[ch_idx];
      detect    = (CMP_W'(filt_result) > CMP_W'(cfg.detect_threshold))
                  && (blind_dec == '0);
      blind_in  = detect ? cfg.blind_ticks : blind_dec;

      arm       = 1'b1;
      parity_in = parity_ff[ch_idx];
      if (detect && cfg.output_control[SKIP_BIT]) begin
         arm       = !parity_ff[ch_idx];
         parity_in = !parity_ff[ch_idx];
      end

      delay_armed = (detect && arm && trigger_enable[channel_ff])
                    ? {1'b0, cfg.delay_ticks} : delay_ff[ch_idx];

      // A set top bit marks an idle timer.
      pin_raised      = pin_ff[ch_idx];
      duration_loaded = duration_ff[ch_idx];
      delay_in        = delay_armed;
      if (!delay_armed[TIMER_W-1]) begin
         if (delay_armed == '0) begin
            pin_raised      = 1'b1;
            duration_loaded = {1'b0, cfg.duration_ticks};
         end
         delay_in = delay_armed - TIMER_W'(1);
      end

      pin_in      = pin_raised;
      duration_in = duration_loaded;
      if (!duration_loaded[TIMER_W-1]) begin
         if (duration_loaded == '0) begin
            pin_in = 1'b0;
         end
         duration_in = duration_loaded - TIMER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            lowpass_ff[i]  <= '0;
            baseline_ff[i] <= '0;
            feature_ff[i]  <= '0;
            blind_ff[i]    <= '0;
            delay_ff[i]    <= '1;
            duration_ff[i] <= '1;
            parity_ff[i]   <= 1'b0;
            pin_ff[i]      <= 1'b0;
         end
      end else begin
         if (cfg.skip_clear) begin
            for (int i = 0; i < CHANNELS; i++) begin
               parity_ff[i] <= 1'b0;
            end
         end

         // The response register fills when the final state completes and empties
         // once its contents have been taken.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  channel_ff <= req_payload.channel;
                  sample_ff  <= req_payload.sample;
                  present_ff <= req_present;
                  state_ff   <= req_present ? S_LOWPASS : S_DONE;
               end
            end
            S_LOWPASS: begin
               state_ff <= S_BASELINE;
            end
            S_BASELINE: begin
               lowpass_new_ff     <= filt_result;
               lowpass_ff[ch_idx] <= filt_result;
               state_ff           <= S_FEATURE;
            end
            S_FEATURE: begin
               baseline_ff[ch_idx] <= filt_result;
               state_ff            <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_payload_ff.out_channel <= channel_ff;
                  if (present_ff) begin
                     rsp_payload_ff.feature   <= FEATURE_W'(filt_result);
                     rsp_payload_ff.detected  <= detect;
                     rsp_payload_ff.pin_level <= pin_in;
                     feature_ff[ch_idx]       <= filt_result;
                     blind_ff[ch_idx]         <= blind_in;
                     delay_ff[ch_idx]         <= delay_in;
                     duration_ff[ch_idx]      <= duration_in;
                     parity_ff[ch_idx]        <= parity_in;
                     pin_ff[ch_idx]           <= pin_in;
                  end else begin
                     rsp_payload_ff.feature   <= '0;
                     rsp_payload_ff.detected  <= 1'b0;
                     rsp_payload_ff.pin_level <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bfod_csr.sv -----
// Configuration register bank of the band feature object detector.
`timescale 1ns / 1ps
`default_nettype none

module bfod_csr
   import bfod_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type                    cfg
);

   cfg_type regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.lowpass_coeff    <= LOWPASS_COEFF_RESET;
         regs_ff.highpass_coeff   <= HIGHPASS_COEFF_RESET;
         regs_ff.feature_coeff    <= FEATURE_COEFF_RESET;
         regs_ff.detect_threshold <= DETECT_THRESHOLD_RESET;
         regs_ff.delay_ticks      <= DELAY_TICKS_RESET;
         regs_ff.duration_ticks   <= DURATION_TICKS_RESET;
         regs_ff.blind_ticks      <= BLIND_TICKS_RESET;
         regs_ff.output_control   <= OUTPUT_CONTROL_RESET;
         regs_ff.skip_clear       <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            REG_LOWPASS_COEFF: begin
               regs_ff.lowpass_coeff <= csr_write_data[COEFF_W-1:0];
            end
            REG_HIGHPASS_COEFF: begin
               regs_ff.highpass_coeff <= csr_write_data[COEFF_W-1:0];
            end
            REG_FEATURE_COEFF: begin
               regs_ff.feature_coeff <= csr_write_data[COEFF_W-1:0];
            end
            REG_DETECT_THRESHOLD: begin
               regs_ff.detect_threshold <= csr_write_data[FEATURE_W-1:0];
            end
            REG_DELAY_TICKS: begin
               regs_ff.delay_ticks <= csr_write_data[TICKS_W-1:0];
            end
            REG_DURATION_TICKS: begin
               regs_ff.duration_ticks <= csr_write_data[TICKS_W-1:0];
            end
            REG_BLIND_TICKS: begin
               regs_ff.blind_ticks <= csr_write_data[TICKS_W-1:0];
            end
            REG_OUTPUT_CONTROL: begin
               regs_ff.output_control <= csr_write_data[CONTROL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The skip parity clear acts on the same edge as the write itself.
   always_comb begin
      cfg            = regs_ff;
      cfg.skip_clear = csr_write_enable
                       && (csr_index_type'(csr_index) == REG_OUTPUT_CONTROL)
                       && csr_write_data[SKIP_BIT];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bfod_smoother.sv -----
// Shared first-order smoothing unit: y' = y + c*(x - y), rounded half up, registered.
`timescale 1ns / 1ps
`default_nettype none

module bfod_smoother
   import bfod_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)(
   input  wire logic                         clock,
   input  wire logic                         enable,
   input  wire logic [COEFF_W-1:0]           coeff,
   input  wire logic [SAMPLE_W+FRAC_BITS-1:0] x_value,
   input  wire logic [SAMPLE_W+FRAC_BITS-1:0] y_value,
   output logic      [SAMPLE_W+FRAC_BITS-1:0] result
);

   localparam int VAL_W  = SAMPLE_W + FRAC_BITS;
   localparam int C_W    = FRAC_BITS + 1;
   localparam int CE_W   = (C_W > COEFF_W) ? C_W : COEFF_W;
   localparam int D_W    = VAL_W + 1;
   localparam int P_W    = C_W + 1 + D_W;
   localparam int ACC_W  = P_W + 1;

   logic [CE_W-1:0]         coeff_ext;
   logic [CE_W-1:0]         one_ext;
   logic [CE_W-1:0]         coeff_clamped;
   logic [C_W-1:0]          c_use;
   logic signed [D_W-1:0]   diff;
   logic signed [P_W-1:0]   product;
   logic signed [ACC_W-1:0] acc;
   logic [VAL_W-1:0]        result_in;
   logic [VAL_W-1:0]        result_ff;

   always_comb begin
      coeff_ext     = CE_W'(coeff);
      one_ext       = CE_W'(1) << FRAC_BITS;
      // A factor above one is taken as exactly one.
      coeff_clamped = (coeff_ext > one_ext) ? one_ext : coeff_ext;
      c_use         = C_W'(coeff_clamped);
      diff          = $signed({1'b0, x_value}) - $signed({1'b0, y_value});
      product       = $signed({1'b0, c_use}) * diff;
      acc           = $signed({{(ACC_W - VAL_W - FRAC_BITS){1'b0}}, y_value,
                               {FRAC_BITS{1'b0}}})
                      + $signed({{(ACC_W - P_W){product[P_W-1]}}, product})
                      + $signed(ACC_W'(1) << (FRAC_BITS - 1));
      result_in     = acc[FRAC_BITS +: VAL_W];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire
